// ----- src/tcp_pkg.sv -----
// shared types, constants and codes of the tiered compaction picker
`timescale 1ns / 1ps
package tcp_pkg;

	// field widths
	localparam int ID_W      = 32;
	localparam int ROW_W     = 32;
	localparam int GS_W      = 5;
	localparam int GF_W      = 7;
	localparam int LIMIT_W   = 40;
	localparam int TIER_W    = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 40;
	localparam int ENTRY_W   = ID_W + ROW_W;

	// largest group, the sum width that follows from it and the product width
	localparam int MAX_GROUP = 16;
	localparam int SUM_W     = ROW_W + $clog2(MAX_GROUP) + 1;
	localparam int PROD_W    = ROW_W + GF_W;

	// default sizes
	localparam int NUM_TIERS_DEF   = 8;
	localparam int QUEUE_DEPTH_DEF = 16;

	// register defaults
	localparam logic [GS_W-1:0]    GS_RST    = GS_W'(4);
	localparam logic [GF_W-1:0]    GF_RST    = GF_W'(4);
	localparam logic [ROW_W-1:0]   FIRST_RST = ROW_W'(8192);
	localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(8388608);

	// commands
	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GROUP_SIZE,
		CFG_GROWTH,
		CFG_FIRST_ROWS,
		CFG_ROW_LIMIT
	} cfg_reg_t;

	// result codes
	typedef enum logic [2:0] {
		STAT_ADDED,
		STAT_DROPPED,
		STAT_NONE,
		STAT_OVER,
		STAT_MEMBER
	} status_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_TIER,
		S_ADD,
		S_SCAN,
		S_SUM,
		S_EMIT,
		S_RESP
	} state_t;

	// input beat
	typedef struct packed {
		logic             cmd;
		logic [ID_W-1:0]  seg_id;
		logic [ROW_W-1:0] row_count;
	} in_beat_t;

	// result beat
	typedef struct packed {
		status_t           status;
		logic [ID_W-1:0]   out_seg_id;
		logic [TIER_W-1:0] tier;
		logic              last;
	} out_beat_t;

endpackage

// ----- src/tiered_compaction_picker_unit.sv -----
// tiered compaction picker: per-tier segment queues held in one synchronous store
// add: one multiply per tier step in S_TIER, then a store write in S_ADD and its result beat
// query: scans the tiers for a full group, sums its rows from the store and, if within the
//   row limit, reads it again to emit members at one beat per cycle while not stalled
// throughput: one item at a time; the next item is taken once the last result is registered
// reset: registers to defaults, all queues empty; the store needs no clearing pass
`timescale 1ns / 1ps
module tiered_compaction_picker_unit import tcp_pkg::*; #(
	parameter int NUM_TIERS   = NUM_TIERS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_beat_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_beat_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int TW    = $clog2(NUM_TIERS);
	localparam int HW    = $clog2(QUEUE_DEPTH);
	localparam int FW    = $clog2(QUEUE_DEPTH + 1);
	localparam int SW    = HW + 1;
	localparam int DEPTH = NUM_TIERS * QUEUE_DEPTH;
	localparam int AW    = $clog2(DEPTH);

	// configuration registers
	logic [GS_W-1:0]    gs_q;
	logic [GF_W-1:0]    gf_q;
	logic [ROW_W-1:0]   first_q;
	logic [LIMIT_W-1:0] limit_q;

	// control state
	state_t          state_q, state_d;
	logic [TW-1:0]   tier_q;
	logic [GS_W-1:0] i_q;
	logic [HW-1:0]   head_q [NUM_TIERS];
	logic [FW-1:0]   fill_q [NUM_TIERS];
	logic            out_valid_q;

	// payload registers
	logic [ID_W-1:0]    id_q;
	logic [ROW_W-1:0]   rows_q;
	logic [ROW_W-1:0]   bound_q;
	logic [SUM_W-1:0]   sum_q;
	status_t            res_status_q;
	logic [TW-1:0]      res_tier_q;
	out_beat_t          out_q;
	logic [ENTRY_W-1:0] rd_q;

	// segment store
	logic [ENTRY_W-1:0] store_mem [DEPTH];

	// combinational signals
	logic [HW-1:0]    head_t;
	logic [FW-1:0]    fill_t;
	logic [PROD_W-1:0] prod;
	logic             tier_done;
	logic             last_tier;
	logic             gs_bad;
	logic             grp_ready;
	logic             q_full;
	logic             last_i;
	logic [SUM_W-1:0] sum_next;
	logic             over;
	logic             out_free;
	logic             fire;
	logic             out_load;
	logic             accept;
	logic             mem_we;
	logic [AW-1:0]    mem_wa;
	logic [AW-1:0]    mem_ra;

	// queue slot: head plus offset, wrapped once
	function automatic logic [HW-1:0] wrap_slot(input logic [HW-1:0] h, input logic [SW-1:0] x);
		logic [SW-1:0] s;
		s = SW'(h) + x;
		if (s >= SW'(QUEUE_DEPTH)) begin
			s = s - SW'(QUEUE_DEPTH);
		end
		return s[HW-1:0];
	endfunction

	// store address of a slot in a tier
	function automatic logic [AW-1:0] addr_of(input logic [TW-1:0] t, input logic [HW-1:0] sl);
		return AW'(t) * AW'(QUEUE_DEPTH) + AW'(sl);
	endfunction

	// per-tier lookups and arithmetic
	assign head_t    = head_q[tier_q];
	assign fill_t    = fill_q[tier_q];
	assign prod      = PROD_W'(bound_q) * PROD_W'(gf_q);
	assign last_tier = (tier_q == TW'(NUM_TIERS - 1));
	assign tier_done = last_tier || (prod > PROD_W'(rows_q));
	assign gs_bad    = (gs_q == '0) || (gs_q > GS_W'(MAX_GROUP))
	                   || (32'(gs_q) > 32'(QUEUE_DEPTH));
	assign grp_ready = (32'(fill_t) >= 32'(gs_q));
	assign q_full    = (fill_t == FW'(QUEUE_DEPTH));
	assign last_i    = (i_q == GS_W'(gs_q - GS_W'(1)));
	assign sum_next  = sum_q + SUM_W'(rd_q[ROW_W-1:0]);
	assign over      = LIMIT_W'(sum_next) > limit_q;
	assign out_free  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (in_data.cmd == CMD_ADD) begin
						state_d = (in_data.row_count < first_q) ? S_ADD : S_TIER;
					end else begin
						state_d = gs_bad ? S_RESP : S_SCAN;
					end
				end
			end
			S_TIER: begin
				if (tier_done) begin
					state_d = S_ADD;
				end
			end
			S_ADD: begin
				state_d = S_RESP;
			end
			S_SCAN: begin
				if (grp_ready) begin
					state_d = S_SUM;
				end else if (last_tier) begin
					state_d = S_RESP;
				end
			end
			S_SUM: begin
				if (last_i) begin
					state_d = over ? S_RESP : S_EMIT;
				end
			end
			S_EMIT: begin
				if (out_free && last_i) begin
					state_d = S_IDLE;
				end
			end
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// outputs of the sequencer: handshakes and store ports
	always_comb begin
		in_ready = 1'b0;
		fire     = 1'b0;
		out_load = 1'b0;
		mem_we   = 1'b0;
		mem_wa   = addr_of(tier_q, wrap_slot(head_t, SW'(fill_t)));
		mem_ra   = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
			end
			S_ADD: begin
				mem_we = !q_full;
			end
			S_SCAN: begin
				mem_ra = addr_of(tier_q, head_t);
			end
			S_SUM: begin
				// read ahead; on the last sum beat restart at the group head
				if (last_i) begin
					mem_ra = addr_of(tier_q, head_t);
				end else begin
					mem_ra = addr_of(tier_q, wrap_slot(head_t, SW'(i_q) + SW'(1)));
				end
			end
			S_EMIT: begin
				fire     = out_free;
				out_load = out_free;
				mem_ra   = addr_of(tier_q, wrap_slot(head_t, SW'(i_q) + SW'(out_free)));
			end
			S_RESP: begin
				out_load = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign cfg_ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gs_q    <= GS_RST;
			gf_q    <= GF_RST;
			first_q <= FIRST_RST;
			limit_q <= LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				CFG_GROUP_SIZE: gs_q    <= cfg_data[GS_W-1:0];
				CFG_GROWTH:     gf_q    <= cfg_data[GF_W-1:0];
				CFG_FIRST_ROWS: first_q <= cfg_data[ROW_W-1:0];
				CFG_ROW_LIMIT:  limit_q <= cfg_data[LIMIT_W-1:0];
				default:        gs_q    <= gs_q;
			endcase
		end
	end

	// sequencer state, tier and member counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tier_q  <= '0;
			i_q     <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					tier_q <= '0;
					i_q    <= '0;
				end
				S_TIER: begin
					if (!tier_done) begin
						tier_q <= tier_q + TW'(1);
					end
				end
				S_SCAN: begin
					i_q <= '0;
					if (!grp_ready && !last_tier) begin
						tier_q <= tier_q + TW'(1);
					end
				end
				S_SUM: begin
					i_q <= last_i ? '0 : i_q + GS_W'(1);
				end
				S_EMIT: begin
					if (fire) begin
						i_q <= i_q + GS_W'(1);
					end
				end
				default: begin
					i_q <= i_q;
				end
			endcase
		end
	end

	// queue heads and fill counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < NUM_TIERS; t++) begin
				head_q[t] <= '0;
				fill_q[t] <= '0;
			end
		end else begin
			if (state_q == S_ADD && !q_full) begin
				fill_q[tier_q] <= fill_t + FW'(1);
			end else if (state_q == S_EMIT && fire && last_i) begin
				head_q[tier_q] <= wrap_slot(head_t, SW'(gs_q));
				fill_q[tier_q] <= fill_t - FW'(gs_q);
			end
		end
	end

	// item payload, tier bound, row sum and pending result
	always_ff @(posedge clk) begin
		if (accept) begin
			id_q    <= in_data.seg_id;
			rows_q  <= in_data.row_count;
			bound_q <= first_q;
			if (in_data.cmd == CMD_QUERY) begin
				res_status_q <= STAT_NONE;
				res_tier_q   <= '0;
			end
		end
		case (state_q)
			S_TIER: begin
				if (!tier_done) begin
					bound_q <= prod[ROW_W-1:0];
				end
			end
			S_ADD: begin
				res_status_q <= q_full ? STAT_DROPPED : STAT_ADDED;
				res_tier_q   <= tier_q;
			end
			S_SCAN: begin
				sum_q <= '0;
			end
			S_SUM: begin
				sum_q <= sum_next;
				if (last_i) begin
					res_status_q <= STAT_OVER;
					res_tier_q   <= tier_q;
				end
			end
			default: begin
				sum_q <= sum_q;
			end
		endcase
	end

	// segment store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[mem_wa] <= {id_q, rows_q};
		end
		rd_q <= store_mem[mem_ra];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (state_q == S_EMIT) begin
				out_q.status     <= STAT_MEMBER;
				out_q.out_seg_id <= rd_q[ENTRY_W-1:ROW_W];
				out_q.tier       <= TIER_W'(tier_q);
				out_q.last       <= last_i;
			end else begin
				out_q.status     <= res_status_q;
				out_q.out_seg_id <= '0;
				out_q.tier       <= TIER_W'(res_tier_q);
				out_q.last       <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- src/tcp_checker.sv -----
// port-level checks of the tiered compaction picker and their binding
`timescale 1ns / 1ps
module tcp_checker import tcp_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input in_beat_t             in_data,
	input logic                 out_valid,
	input logic                 out_ready,
	input out_beat_t            out_data,
	input logic                 cfg_valid,
	input logic                 cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0]     cfg_data
);

	// a stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// single-beat answers close the item and carry no segment id
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != STAT_MEMBER |-> out_data.last && out_data.out_seg_id == '0)
		else $error("single-beat answer without last or with an id");

	// nothing ready reports tier zero
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == STAT_NONE |-> out_data.tier == '0)
		else $error("nothing-ready answer with a tier");

	// no new item while a group is still being emitted
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == STAT_MEMBER && !out_data.last |-> !in_ready)
		else $error("input taken in the middle of a group");

endmodule

bind tiered_compaction_picker_unit tcp_checker u_tcp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.cfg_index (cfg_index),
	.cfg_data  (cfg_data)
);
